// File: sv/ihc_pkg.sv
// shared types and constants for the ipv4 header checker
`default_nettype none

package ihc_pkg;

    // largest packet length tracked by default
    localparam int MAX_PACKET_BYTES_DEF = 65535;

    // smallest legal header and packet length in bytes
    localparam int MIN_HEADER_BYTES = 20;

    // supported protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // verdict codes
    typedef enum logic [2:0] {
        ST_ICMP_OK      = 3'd0,
        ST_UDP_OK       = 3'd1,
        ST_SHORT        = 3'd2,
        ST_BAD_VERSION  = 3'd3,
        ST_BAD_IHL      = 3'd4,
        ST_BAD_CHECKSUM = 3'd5,
        ST_BAD_PROTO    = 3'd6
    } status_t;

    // header fields as captured so far
    typedef struct packed {
        logic [3:0]  version;
        logic [5:0]  hdr_len;
        logic [15:0] csum_acc;
        logic [15:0] stored_csum;
        logic [15:0] datagram_len;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } hdr_fields_t;

endpackage

`default_nettype wire

// File: sv/ipv4_header_checker.sv
// ipv4 header checker top level: input register, field capture, verdict, result register
// a last byte is held in the input register, then its verdict is loaded into the result register
// throughput: one byte per cycle; the input stalls only while a finished verdict
//   waits in the result register and the held byte is itself a last byte
// reset: asynchronous active low, clears the byte counter, all captured fields,
//   the checksum sum and both valid flags
`default_nettype none

module ipv4_header_checker #(
    parameter int MAX_PACKET_BYTES = ihc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   byte_valid,
    output logic        byte_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic   last_byte,
    output logic        verdict_valid,
    input  wire logic   verdict_stall,
    output logic [2:0]  status,
    output logic [7:0]  protocol,
    output logic [31:0] source_address,
    output logic [31:0] destination_address,
    output logic [5:0]  header_bytes,
    output logic [15:0] payload_length
);

    import ihc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

    logic             held_valid;
    logic [7:0]       held_data;
    logic             held_last;
    logic             advance;
    logic             load;
    logic             blocked;
    hdr_fields_t      fields_next;
    logic [CNT_W-1:0] packet_len;
    status_t          verdict_status;
    logic [15:0]      payload_size;

    // a held byte moves on unless its verdict has nowhere to go
    assign advance = held_valid && !(held_last && blocked);
    assign load    = advance && held_last;

    // input register
    ihc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data),
        .held_last  (held_last),
        .byte_stall (byte_stall)
    );

    // header state
    ihc_field_capture #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_field_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data        (held_data),
        .last        (held_last),
        .fields_next (fields_next),
        .packet_len  (packet_len)
    );

    // classification
    ihc_verdict #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_verdict (
        .fields       (fields_next),
        .packet_len   (packet_len),
        .status       (verdict_status),
        .payload_size (payload_size)
    );

    // result register
    ihc_out_stage u_out_stage (
        .clk                 (clk),
        .rst_n               (rst_n),
        .load                (load),
        .status_in           (verdict_status),
        .fields_in           (fields_next),
        .payload_in          (payload_size),
        .verdict_stall       (verdict_stall),
        .verdict_valid       (verdict_valid),
        .blocked             (blocked),
        .status              (status),
        .protocol            (protocol),
        .source_address      (source_address),
        .destination_address (destination_address),
        .header_bytes        (header_bytes),
        .payload_length      (payload_length)
    );

`ifndef SYNTHESIS
    // input only stalls behind a waiting verdict with a last byte held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (held_valid && held_last && verdict_valid && verdict_stall))
        else $error("byte stall without a blocked verdict");

    // a new verdict never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(verdict_valid && verdict_stall))
        else $error("verdict loaded over a waiting verdict");

    // a verdict appears only after a last byte was processed
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict_valid) |-> $past(load))
        else $error("verdict valid without a last byte");

    // status code stays within the defined verdicts
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (status != 3'd7))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire

// File: sv/ihc_in_stage.sv
// input register for the packet byte stream
`default_nettype none

module ihc_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       advance,
    output logic            held_valid,
    output logic [7:0]      held_data,
    output logic            held_last,
    output logic            byte_stall
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    // held item blocks a new one only when it cannot move on
    assign byte_stall = valid_reg && !advance;

    // control part of the register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            valid_reg <= byte_valid;
        end
    end

    // payload part of the register
    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;
    assign held_last  = last_reg;

endmodule

`default_nettype wire

// File: sv/ihc_field_capture.sv
// byte counter, header field capture and running ones' complement sum
`default_nettype none

module ihc_field_capture #(
    parameter int MAX_PACKET_BYTES = ihc_pkg::MAX_PACKET_BYTES_DEF,
    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   data,
    input  wire logic         last,
    output ihc_pkg::hdr_fields_t fields_next,
    output logic [CNT_W-1:0]  packet_len
);

    import ihc_pkg::*;

    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    // fixed byte offsets inside the header
    localparam int OFF_VER_IHL  = 0;
    localparam int OFF_TOTAL_HI = 2;
    localparam int OFF_TOTAL_LO = 3;
    localparam int OFF_PROTO    = 9;
    localparam int OFF_CSUM_HI  = 10;
    localparam int OFF_CSUM_LO  = 11;
    localparam int OFF_SRC      = 12;
    localparam int OFF_DST      = 16;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       high_reg;
    logic [7:0]       high_next;
    hdr_fields_t      fields_reg;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] sum;
        sum = {1'b0, acc} + {1'b0, word};
        return sum[16] ? (sum[15:0] + 16'd1) : sum[15:0];
    endfunction

    // saturating byte index and packet length
    always_comb
    begin
        if (count_reg == CNT_W'(MAX_PACKET_BYTES))
        begin
            count_next = count_reg;
            packet_len = CNT_W'(MAX_PACKET_BYTES);
        end
        else
        begin
            count_next = count_reg + 1'b1;
            packet_len = count_reg + 1'b1;
        end
    end

    // field capture at fixed offsets and checksum update
    always_comb
    begin
        fields_next = fields_reg;
        high_next   = high_reg;

        if (count_reg == CNT_W'(OFF_VER_IHL))
        begin
            fields_next.version = data[7:4];
            fields_next.hdr_len = {data[3:0], 2'b00};
        end
        if (count_reg == CNT_W'(OFF_TOTAL_HI))
        begin
            fields_next.datagram_len = {data, 8'h00};
        end
        if (count_reg == CNT_W'(OFF_TOTAL_LO))
        begin
            fields_next.datagram_len = {fields_reg.datagram_len[15:8], data};
        end
        if (count_reg == CNT_W'(OFF_PROTO))
        begin
            fields_next.proto = data;
        end
        if (count_reg == CNT_W'(OFF_CSUM_HI))
        begin
            fields_next.stored_csum = {data, 8'h00};
        end
        if (count_reg == CNT_W'(OFF_CSUM_LO))
        begin
            fields_next.stored_csum = {fields_reg.stored_csum[15:8], data};
        end
        if (count_reg inside {[OFF_SRC:OFF_SRC + 3]})
        begin
            fields_next.src_addr = {fields_reg.src_addr[23:0], data};
        end
        if (count_reg inside {[OFF_DST:OFF_DST + 3]})
        begin
            fields_next.dst_addr = {fields_reg.dst_addr[23:0], data};
        end

        // only header bytes enter the sum, checksum word counts as zero
        if (CMP_W'(count_reg) < CMP_W'(fields_next.hdr_len))
        begin
            if (!count_reg[0])
            begin
                high_next = data;
            end
            else if (count_reg == CNT_W'(OFF_CSUM_LO))
            begin
                fields_next.csum_acc = ones_add(fields_reg.csum_acc, 16'h0000);
            end
            else
            begin
                fields_next.csum_acc = ones_add(fields_reg.csum_acc, {high_reg, data});
            end
        end
    end

    // state registers, cleared after the last byte of a packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            high_reg   <= '0;
            fields_reg <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                count_reg  <= '0;
                high_reg   <= '0;
                fields_reg <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                high_reg   <= high_next;
                fields_reg <= fields_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/ihc_verdict.sv
// verdict and payload length from the captured header fields
`default_nettype none

module ihc_verdict #(
    parameter int MAX_PACKET_BYTES = ihc_pkg::MAX_PACKET_BYTES_DEF,
    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  wire ihc_pkg::hdr_fields_t fields,
    input  wire logic [CNT_W-1:0] packet_len,
    output ihc_pkg::status_t     status,
    output logic [15:0]          payload_size
);

    import ihc_pkg::*;

    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    // checks in priority order
    always_comb
    begin
        if (packet_len < CNT_W'(MIN_HEADER_BYTES))
        begin
            status = ST_SHORT;
        end
        else if (fields.version != 4'd4)
        begin
            status = ST_BAD_VERSION;
        end
        else if ((fields.hdr_len < 6'(MIN_HEADER_BYTES)) ||
                 (CMP_W'(fields.hdr_len) > CMP_W'(packet_len)))
        begin
            status = ST_BAD_IHL;
        end
        else if (~fields.csum_acc != fields.stored_csum)
        begin
            status = ST_BAD_CHECKSUM;
        end
        else if (fields.proto == PROTO_ICMP)
        begin
            status = ST_ICMP_OK;
        end
        else if (fields.proto == PROTO_UDP)
        begin
            status = ST_UDP_OK;
        end
        else
        begin
            status = ST_BAD_PROTO;
        end
    end

    // payload length saturates at zero
    always_comb
    begin
        if (fields.datagram_len >= {10'd0, fields.hdr_len})
        begin
            payload_size = fields.datagram_len - {10'd0, fields.hdr_len};
        end
        else
        begin
            payload_size = 16'd0;
        end
    end

endmodule

`default_nettype wire

// File: sv/ihc_out_stage.sv
// result register for the verdict item
`default_nettype none

module ihc_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire ihc_pkg::status_t     status_in,
    input  wire ihc_pkg::hdr_fields_t fields_in,
    input  wire logic [15:0]     payload_in,
    input  wire logic            verdict_stall,
    output logic                 verdict_valid,
    output logic                 blocked,
    output logic [2:0]           status,
    output logic [7:0]           protocol,
    output logic [31:0]          source_address,
    output logic [31:0]          destination_address,
    output logic [5:0]           header_bytes,
    output logic [15:0]          payload_length
);

    import ihc_pkg::*;

    logic        valid_reg;
    logic [2:0]  status_reg;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [5:0]  hdr_len_reg;
    logic [15:0] payload_reg;

    // a waiting verdict that is not taken blocks the next one
    assign blocked = valid_reg && verdict_stall;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!verdict_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // verdict payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= status_in;
            proto_reg   <= fields_in.proto;
            src_reg     <= fields_in.src_addr;
            dst_reg     <= fields_in.dst_addr;
            hdr_len_reg <= fields_in.hdr_len;
            payload_reg <= payload_in;
        end
    end

    assign verdict_valid       = valid_reg;
    assign status              = status_reg;
    assign protocol            = proto_reg;
    assign source_address      = src_reg;
    assign destination_address = dst_reg;
    assign header_bytes        = hdr_len_reg;
    assign payload_length      = payload_reg;

endmodule

`default_nettype wire
